// ===== rtl/three_axis_route_player_macros.svh =====
// Assertion macros for the route player checker.
`ifndef THREE_AXIS_ROUTE_PLAYER_MACROS_SVH
`define THREE_AXIS_ROUTE_PLAYER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TARP_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the cycle after the trigger.
`define TARP_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/tarp_pkg.sv =====
// Shared types and constants for the route player.
package tarp_pkg;
  localparam int ROUTE_DEPTH_DEF = 256;
  localparam int PULSE_BITS_DEF  = 24;
  localparam logic [15:0] MIN_RATE = 16'd10;
  localparam logic [15:0] MAX_RATE = 16'hFFFF;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_CLEAR = 3'd2;
  localparam logic [2:0] REQ_START = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;

  localparam logic [2:0] CFG_BASE   = 3'd0;
  localparam logic [2:0] CFG_RHOME  = 3'd1;
  localparam logic [2:0] CFG_LOOP   = 3'd2;
  localparam logic [2:0] CFG_MIRROR = 3'd3;
  localparam logic [2:0] CFG_LIMIT  = 3'd4;
  localparam logic [2:0] CFG_HOMEX  = 3'd5;
  localparam logic [2:0] CFG_HOMEY  = 3'd6;
  localparam logic [2:0] CFG_HOMEZ  = 3'd7;

  typedef struct packed {
    logic [2:0]                req_type;
    logic                      motors_done;
    logic [PULSE_BITS_DEF-1:0] now_x;
    logic [PULSE_BITS_DEF-1:0] now_y;
    logic [PULSE_BITS_DEF-1:0] now_z;
    logic [PULSE_BITS_DEF-1:0] point_x;
    logic [PULSE_BITS_DEF-1:0] point_y;
    logic [PULSE_BITS_DEF-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic                      move_valid;
    logic [PULSE_BITS_DEF-1:0] target_x;
    logic [PULSE_BITS_DEF-1:0] target_y;
    logic [PULSE_BITS_DEF-1:0] target_z;
    logic [15:0]               rate_x;
    logic [15:0]               rate_y;
    logic [15:0]               rate_z;
    logic                      add_refused;
    logic                      running;
    logic                      last;
  } out_word_t;

  // divider control between the sequencer and the rate unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== rtl/tarp_rate_div.sv =====
// Bit-serial rate unit: q = sat(num*base/den), one quotient bit per cycle in the divide phase.
module tarp_rate_div import tarp_pkg::*; #(
  parameter int PB = PULSE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PB-1:0] num,
  input  logic [PB-1:0] den,
  input  logic [15:0]   base,
  output div_ctl_t      ctl,
  output logic [15:0]   q
);
  localparam int NW = PB + 16;
  localparam int CW = $clog2(NW + 1);
  // product built by shift-add over the 16 bits of base, then restoring division
  logic [NW-1:0] prod, quo;
  logic [PB:0]   rem;
  logic [15:0]   mb;
  logic [PB-1:0] dn;
  logic [CW-1:0] cnt;
  logic          mul_ph, busy, done;
  logic [PB:0]   trial;

  assign trial = {rem[PB-1:0], quo[NW-1]} - {1'b0, dn};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      mul_ph <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      mul_ph <= 1'b1;
      prod <= '0;
      mb <= base;
      dn <= den;
      quo <= NW'(num);
      cnt <= CW'(16);
    end else if (busy && mul_ph) begin
      // prod = prod*2 + (msb of mb ? num : 0), num held in quo low bits;
      // mb rotates so it holds base again when the multiply phase ends
      prod <= {prod[NW-2:0], 1'b0} + (mb[15] ? quo : '0);
      mb <= {mb[14:0], mb[15]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        mul_ph <= 1'b0;
        cnt <= CW'(NW);
        rem <= '0;
      end
    end else if (busy) begin
      if (cnt == CW'(NW)) begin
        quo <= prod;
        cnt <= cnt - 1'b1;
      end else begin
        if (!trial[PB]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[PB-1:0], quo[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else cnt <= cnt - 1'b1;
      end
    end
  end

  // cnt counts NW-1 .. 0 for NW steps; quo holds quotient after last
  logic [15:0] qs;
  always_comb begin
    if (dn == '0) qs = mb;
    else if (|quo[NW-1:16]) qs = MAX_RATE;
    else qs = quo[15:0];
    q = (qs < MIN_RATE) ? MIN_RATE : qs;
  end
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

// ===== rtl/three_axis_route_player.sv =====
// Route player: a point table played back as three-axis moves with scaled speeds.
//
// One word in, one or two words out. A tick that plays a table entry
// reads the point table (one registered read); every move runs two
// serial rate computations through a single shared unit: 16 shift-add
// steps then pulse-width+16 divide steps each. The x rate is base_speed;
// y and z are scaled so all axes arrive together, floored at 10 and
// saturated at 65535. A zero divisor yields base_speed.
// The table has no reset; only entries below the point count are read.
// One item is worked at a time; the input is ready again once every
// result word of the previous item has been taken.
module three_axis_route_player import tarp_pkg::*; #(
  parameter int ROUTE_DEPTH = ROUTE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int AW = $clog2(ROUTE_DEPTH);
  localparam int CW = $clog2(ROUTE_DEPTH + 1);
  localparam int PB = PULSE_BITS_DEF;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_PLAN  = 8'b00000100,
    S_DIVY  = 8'b00001000,
    S_DIVZ  = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_HOME  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;
  state_t state;

  // configuration
  logic [15:0] base_speed;
  logic return_home, loop_enable, mirror_enable;
  logic [31:0] loop_limit;
  logic [PB-1:0] home_x, home_y, home_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= '0; return_home <= 1'b0; loop_enable <= 1'b0;
      mirror_enable <= 1'b0; loop_limit <= '0;
      home_x <= '0; home_y <= '0; home_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:   base_speed <= cfg_data[15:0];
        CFG_RHOME:  return_home <= cfg_data[0];
        CFG_LOOP:   loop_enable <= cfg_data[0];
        CFG_MIRROR: mirror_enable <= cfg_data[0];
        CFG_LIMIT:  loop_limit <= cfg_data;
        CFG_HOMEX:  home_x <= cfg_data[PB-1:0];
        CFG_HOMEY:  home_y <= cfg_data[PB-1:0];
        CFG_HOMEZ:  home_z <= cfg_data[PB-1:0];
        default: ;
      endcase
    end
  end

  // point table, one write and one registered read
  logic [3*PB-1:0] route_mem [ROUTE_DEPTH];
  logic [3*PB-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;

  logic [CW-1:0] point_count, play_index;
  logic [31:0]   loops_done;
  logic          auto_active;

  assign mem_we = in_valid && in_ready && in_data.req_type == REQ_ADD &&
                  point_count < CW'(ROUTE_DEPTH);
  always_ff @(posedge clk) begin
    if (mem_we) route_mem[point_count[AW-1:0]] <=
      {in_data.point_x[PB-1:0], in_data.point_y[PB-1:0], in_data.point_z[PB-1:0]};
    rd_data <= route_mem[rd_addr];
  end
  assign rd_addr = play_index[AW-1:0];

  // item latched
  logic [PB-1:0] now_x, now_y, now_z;
  logic [PB-1:0] tgt_x, tgt_y, tgt_z;
  logic [PB-1:0] dx, dy, dz;
  logic [15:0]   ry, rz;
  logic          home_pending, refused, first_out;

  // serial rate unit
  logic          dstart;
  logic [PB-1:0] dnum, dden;
  div_ctl_t      dctl;
  logic [15:0]   dq;
  tarp_rate_div #(.PB(PB)) u_div (
    .clk, .rst, .start(dstart), .num(dnum), .den(dden), .base(base_speed),
    .ctl(dctl), .q(dq)
  );

  function automatic logic [PB-1:0] adiff(logic [PB-1:0] a, logic [PB-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction
  function automatic logic [PB-1:0] mir(logic [PB-1:0] h, logic [PB-1:0] c);
    logic [PB:0] t;
    t = {h, 1'b0};
    if ({1'b0, c} >= t) return '0;
    t = t - {1'b0, c};
    return t[PB] ? '1 : t[PB-1:0];
  endfunction

  // divider operands depend on which axis: y uses dx/dy; z uses dx/dz or dy/dz
  always_comb begin
    dnum = (dx != '0) ? dx : dy;
    dden = (state == S_DIVY) ? dy : dz;
  end

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      point_count <= '0; play_index <= '0; loops_done <= '0;
      auto_active <= 1'b0; out_valid <= 1'b0; home_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          now_x <= in_data.now_x[PB-1:0];
          now_y <= in_data.now_y[PB-1:0];
          now_z <= in_data.now_z[PB-1:0];
          refused <= 1'b0;
          home_pending <= 1'b0;
          first_out <= 1'b0;
          state <= S_OUT;
          case (in_data.req_type)
            REQ_ADD:
              if (point_count < CW'(ROUTE_DEPTH)) point_count <= point_count + 1'b1;
              else refused <= 1'b1;
            REQ_CLEAR: point_count <= '0;
            REQ_START: auto_active <= 1'b1;
            REQ_STOP:  auto_active <= 1'b0;
            REQ_TICK:
              if (auto_active && in_data.motors_done) begin
                if (play_index < point_count) begin
                  state <= S_READ;
                end else begin
                  play_index <= '0;
                  if (loop_enable) begin
                    if (loops_done >= loop_limit) begin
                      auto_active <= 1'b0; loops_done <= '0;
                      home_pending <= return_home;
                    end else loops_done <= loops_done + 1'b1;
                    tgt_x <= mirror_enable ? mir(home_x, in_data.now_x[PB-1:0]) : home_x;
                    tgt_y <= mirror_enable ? mir(home_y, in_data.now_y[PB-1:0]) : home_y;
                    tgt_z <= mirror_enable ? mir(home_z, in_data.now_z[PB-1:0]) : home_z;
                    state <= S_PLAN;
                  end else begin
                    auto_active <= 1'b0; loops_done <= '0;
                    if (return_home) begin
                      tgt_x <= home_x; tgt_y <= home_y; tgt_z <= home_z;
                      state <= S_PLAN;
                    end
                  end
                end
              end
            default: ;
          endcase
        end
        S_READ: begin
          // second read of the same entry is under way; advance the index now
          play_index <= play_index + 1'b1;
          state <= S_HOME;
        end
        S_HOME: begin
          {tgt_x, tgt_y, tgt_z} <= rd_data;
          state <= S_PLAN;
        end
        S_PLAN: begin
          dx <= adiff(now_x, tgt_x);
          dy <= adiff(now_y, tgt_y);
          dz <= adiff(now_z, tgt_z);
          dstart <= 1'b1;
          state <= S_DIVY;
        end
        S_DIVY: if (dctl.done) begin
          ry <= (dx != '0) ? dq : ((base_speed < MIN_RATE) ? MIN_RATE : base_speed);
          dstart <= 1'b1;
          state <= S_DIVZ;
        end
        S_DIVZ: if (dctl.done) begin
          rz <= (dx == '0 && dy == '0) ?
                ((base_speed < MIN_RATE) ? MIN_RATE : base_speed) : dq;
          first_out <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid && !first_out) out_valid <= 1'b1;
          else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (home_pending) begin
              home_pending <= 1'b0;
              tgt_x <= home_x; tgt_y <= home_y; tgt_z <= home_z;
              state <= S_PLAN;
            end else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // play_index holds from accept through S_READ, so both read cycles
  // address the entry being played.
  always_comb begin
    out_data = '0;
    out_data.move_valid  = first_out;
    out_data.add_refused = refused && !first_out;
    out_data.running     = auto_active;
    out_data.last        = !home_pending;
    if (first_out) begin
      out_data.target_x = tgt_x;
      out_data.target_y = tgt_y;
      out_data.target_z = tgt_z;
      out_data.rate_x = base_speed;
      out_data.rate_y = ry;
      out_data.rate_z = rz;
    end
  end
endmodule

// ===== rtl/tarp_checker.sv =====
// Port-level checker for the route player, bound to the top level.
`include "three_axis_route_player_macros.svh"
module tarp_checker import tarp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  `TARP_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready, "input taken with word pending")
  `TARP_ASSERT_IMP(a_move_clean, clk, rst, out_valid && out_data.move_valid, !out_data.add_refused, "refusal in move word")
  `TARP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "word dropped while stalled")
  `TARP_ASSERT_IMP(a_rate_floor, clk, rst, out_valid && out_data.move_valid, out_data.rate_y >= MIN_RATE && out_data.rate_z >= MIN_RATE, "rate below floor")
endmodule

bind three_axis_route_player tarp_checker u_tarp_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
